// ===== src/modular_exponentiation_core_defines.svh =====
// Assertion macros for the modular exponentiation core checker.
// Depends on nothing; included by files that carry assertions.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Check a property on every rising edge while reset is released.
`define MEXP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("modexp check failed");

// Check a property on every rising edge, reset included.
`define MEXP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("modexp check failed");

`endif

// ===== src/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation core.
// Depends on nothing.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int unsigned BASE_W  = 32;
  localparam int unsigned FIELD_W = 31;
  localparam int unsigned STEP_W  = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_MULT,
    ST_SQUARE
  } state_t;

endpackage

// ===== src/modular_exponentiation_core.sv =====
// Modular exponentiation core: base^exponent mod modulus, right-to-left
// square-and-multiply over one shared shift-add modular multiplier.
// Depends on mexp_pkg.
//
// A beat is taken when start is high and busy is low; busy then stays high
// until the result. The base is first reduced modulo the modulus; then each
// exponent bit takes a scan step, a multiply into the accumulator when the
// bit is set, and a square of the base, and a last scan step ends the run
// when the exponent is zero. out_valid rises as busy falls. The shift-add
// modular multiplier handles one multiplier bit per cycle. The result appears
// on out_power_residue for exactly one cycle with out_valid high; it cannot
// be stalled, so capture it then. A zero modulus acts as a modulus of one,
// and a zero exponent gives one.
`timescale 1ns / 1ps

module modular_exponentiation_core #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mexp_pkg::BASE_W-1:0]   in_base_value,
  input  logic [mexp_pkg::FIELD_W-1:0]  in_exponent,
  input  logic [mexp_pkg::FIELD_W-1:0]  in_modulus,
  output logic                          out_valid,
  output logic [mexp_pkg::FIELD_W-1:0]  out_power_residue
);
  import mexp_pkg::*;

  localparam int unsigned USE_BITS = (OPERAND_BITS < BASE_W) ? OPERAND_BITS : BASE_W;
  localparam logic [63:0] MASK_FULL = (64'd1 << USE_BITS) - 64'd1;
  localparam logic [BASE_W-1:0] BASE_MASK = MASK_FULL[BASE_W-1:0];

  state_t state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [FIELD_W-1:0] rem_r, rem_nxt;
  logic [BASE_W-1:0]  mlier_r, mlier_nxt;
  logic [FIELD_W-1:0] addend_r, addend_nxt;
  logic [FIELD_W-1:0] mod_r, mod_nxt;
  logic [FIELD_W-1:0] exp_r, exp_nxt;
  logic [FIELD_W-1:0] base_r, base_nxt;
  logic [FIELD_W-1:0] acc_r, acc_nxt;

  // shared step: rem = (2*rem + bit*addend) mod m, operands below m
  logic [FIELD_W+2:0] sum_w, sub1_w, sub2_w;
  logic [FIELD_W-1:0] step_w;
  logic               last_w;

  always_comb begin
    sum_w  = {2'b00, rem_r, 1'b0} + (mlier_r[BASE_W-1] ? {3'b000, addend_r} : '0);
    sub1_w = sum_w - {3'b000, mod_r};
    sub2_w = sum_w - {2'b00, mod_r, 1'b0};
    if (!sub2_w[FIELD_W+2]) begin
      step_w = sub2_w[FIELD_W-1:0];
    end else if (!sub1_w[FIELD_W+2]) begin
      step_w = sub1_w[FIELD_W-1:0];
    end else begin
      step_w = sum_w[FIELD_W-1:0];
    end
    last_w = (cnt_r == '1);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    rem_nxt       = rem_r;
    mlier_nxt     = mlier_r;
    addend_nxt    = addend_r;
    mod_nxt       = mod_r;
    exp_nxt       = exp_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          mod_nxt    = (in_modulus == '0) ? FIELD_W'(1) : in_modulus;
          exp_nxt    = in_exponent;
          mlier_nxt  = in_base_value & BASE_MASK;
          addend_nxt = FIELD_W'(1);
          rem_nxt    = '0;
          acc_nxt    = FIELD_W'(1);
          cnt_nxt    = '0;
          state_nxt  = ST_REDUCE;
        end
      end
      ST_REDUCE, ST_MULT, ST_SQUARE: begin
        rem_nxt   = step_w;
        mlier_nxt = {mlier_r[BASE_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + STEP_W'(1);
        if (last_w) begin
          priority case (state_r)
            ST_MULT: begin
              acc_nxt    = step_w;
              mlier_nxt  = {1'b0, base_r};
              addend_nxt = base_r;
              rem_nxt    = '0;
              state_nxt  = ST_SQUARE;
            end
            ST_SQUARE: begin
              base_nxt  = step_w;
              exp_nxt   = {1'b0, exp_r[FIELD_W-1:1]};
              state_nxt = ST_SCAN;
            end
            default: begin
              base_nxt  = step_w;
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        if (exp_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (exp_r[0]) begin
          mlier_nxt  = {1'b0, acc_r};
          addend_nxt = base_r;
          state_nxt  = ST_MULT;
        end else begin
          mlier_nxt  = {1'b0, base_r};
          addend_nxt = base_r;
          state_nxt  = ST_SQUARE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    mlier_r  <= mlier_nxt;
    addend_r <= addend_nxt;
    mod_r    <= mod_nxt;
    exp_r    <= exp_nxt;
    base_r   <= base_nxt;
    acc_r    <= acc_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_power_residue = acc_r;

endmodule

// ===== src/mexp_checker.sv =====
// Port-level checks for the modular exponentiation core, with its bind.
// Depends on modular_exponentiation_core_defines.svh.
`timescale 1ns / 1ps
`include "modular_exponentiation_core_defines.svh"

module mexp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `MEXP_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  `MEXP_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid)
  `MEXP_ASSERT(a_strobe_idle, clk, rst_n, out_valid |-> !busy)
  `MEXP_ASSERT(a_done_delivers, clk, rst_n, ($fell(busy) && $past(rst_n)) |-> out_valid)

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
